FILE: hw/rtl/srtp_hp_pkg.sv
// ----------------------------------------------------------------------------
// srtp_hp_pkg
// Shared types and constants for the RTP/SRTP packet header parser: channel
// payloads, configuration register indices, status codes and the per-packet
// record passed from the byte front end to the length back end.
// ----------------------------------------------------------------------------
`default_nettype none

package srtp_hp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int LEN_W            = 12;
  localparam int BASE_W           = 7;
  localparam int CMP_W            = (POS_W > BASE_W) ? POS_W : BASE_W;
  localparam int HLEN_W           = 19;
  localparam int TRAIL_W          = 7;
  localparam int BASE_HDR_BYTES   = 12;
  localparam int EXT_HDR_BYTES    = 4;

  localparam logic [1:0] RTP_VERSION     = 2'd2;
  localparam logic [5:0] AUTH_TAG_RESET  = 6'd10;

  typedef enum logic [1:0] {
    CFG_SECURE_MODE    = 2'd0,
    CFG_AUTH_TAG_BYTES = 2'd1,
    CFG_MKI_BYTES      = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_BASE    = 3'd1,
    ST_BAD_VERSION   = 3'd2,
    ST_SHORT_EXT     = 3'd3,
    ST_SHORT_HEADER  = 3'd4,
    ST_SHORT_TRAILER = 3'd5,
    ST_TOO_LONG      = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] rollover_count;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] byte_count;
    logic [11:0] hdr_bytes;
    logic [11:0] body_bytes;
    logic [11:0] mki_offset;
    logic [11:0] tag_offset;
    logic [15:0] sequence_number;
    logic [31:0] source_id;
    logic [47:0] packet_index;
  } out_t;

  typedef struct packed {
    logic       secure_mode;
    logic [5:0] auth_tag_bytes;
    logic [4:0] mki_bytes;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] count;
    logic             overlong;
    logic [1:0]       version;
    logic             ext_flag;
    logic [3:0]       csrc_count;
    logic [15:0]      ext_words;
    logic [15:0]      seq;
    logic [31:0]      ssrc;
    logic [31:0]      rollover;
  } rec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srtp_hp_front.sv
// ----------------------------------------------------------------------------
// srtp_hp_front
// Byte front end: tracks the position in the packet, latches header fields
// and hands a packet record to the queue on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_hp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire srtp_hp_pkg::in_t  in_data,
  output logic                   rec_push,
  output srtp_hp_pkg::rec_t      rec_data,
  input  wire logic              rec_full
);
  import srtp_hp_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [1:0]       version_field;
  logic             extension_flag;
  logic [3:0]       csrc_count;
  logic [15:0]      seq_latch;
  logic [31:0]      ssrc_latch;
  logic [15:0]      extension_words;
  logic [31:0]      rollover_latch;
  logic             overlong_flag;

  logic [POS_W-1:0] byte_position_next;
  logic [1:0]       version_field_next;
  logic             extension_flag_next;
  logic [3:0]       csrc_count_next;
  logic [15:0]      seq_latch_next;
  logic [31:0]      ssrc_latch_next;
  logic [15:0]      extension_words_next;
  logic [31:0]      rollover_latch_next;
  logic             overlong_flag_next;

  logic             first;
  logic             accept;
  logic [BASE_W-1:0] base_len;
  logic [CMP_W-1:0]  pos_cmp;
  logic [CMP_W-1:0]  base_cmp;
  logic [7:0]        b;

  assign in_ready = !rec_full;
  assign accept   = in_valid && in_ready;
  assign first    = (byte_position == '0);
  assign b        = in_data.packet_byte;
  assign base_len = BASE_W'(BASE_HDR_BYTES) + {1'b0, csrc_count, 2'b00};
  assign pos_cmp  = CMP_W'(byte_position);
  assign base_cmp = CMP_W'(base_len);

  always_comb begin
    version_field_next   = first ? 2'd0  : version_field;
    extension_flag_next  = first ? 1'b0  : extension_flag;
    csrc_count_next      = first ? 4'd0  : csrc_count;
    seq_latch_next       = first ? 16'd0 : seq_latch;
    ssrc_latch_next      = first ? 32'd0 : ssrc_latch;
    extension_words_next = first ? 16'd0 : extension_words;
    rollover_latch_next  = first ? in_data.rollover_count : rollover_latch;
    overlong_flag_next   = first ? 1'b0  : overlong_flag;
    byte_position_next   = byte_position;
    if (CMP_W'(byte_position) >= CMP_W'(MAX_PACKET_BYTES)) begin
      overlong_flag_next = 1'b1;
      byte_position_next = POS_W'(MAX_PACKET_BYTES);
    end else begin
      byte_position_next = byte_position + POS_W'(1);
      if (pos_cmp == CMP_W'(0)) begin
        version_field_next  = b[7:6];
        extension_flag_next = b[4];
        csrc_count_next     = b[3:0];
      end else if (pos_cmp == CMP_W'(2)) begin
        seq_latch_next[15:8] = b;
      end else if (pos_cmp == CMP_W'(3)) begin
        seq_latch_next[7:0] = b;
      end else if (pos_cmp >= CMP_W'(8) && pos_cmp <= CMP_W'(11)) begin
        ssrc_latch_next = {ssrc_latch[23:0], b};
      end else if (pos_cmp == base_cmp + CMP_W'(2)) begin
        extension_words_next[15:8] = b;
      end else if (pos_cmp == base_cmp + CMP_W'(3)) begin
        extension_words_next[7:0] = b;
      end
    end
  end

  assign rec_push = accept && in_data.last_byte;

  always_comb begin
    rec_data.count      = byte_position_next;
    rec_data.overlong   = overlong_flag_next;
    rec_data.version    = version_field_next;
    rec_data.ext_flag   = extension_flag_next;
    rec_data.csrc_count = csrc_count_next;
    rec_data.ext_words  = extension_words_next;
    rec_data.seq        = seq_latch_next;
    rec_data.ssrc       = ssrc_latch_next;
    rec_data.rollover   = rollover_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      version_field   <= '0;
      extension_flag  <= 1'b0;
      csrc_count      <= '0;
      seq_latch       <= '0;
      ssrc_latch      <= '0;
      extension_words <= '0;
      rollover_latch  <= '0;
      overlong_flag   <= 1'b0;
    end else if (accept) begin
      version_field   <= version_field_next;
      extension_flag  <= extension_flag_next;
      csrc_count      <= csrc_count_next;
      seq_latch       <= seq_latch_next;
      ssrc_latch      <= ssrc_latch_next;
      extension_words <= extension_words_next;
      rollover_latch  <= rollover_latch_next;
      if (in_data.last_byte) begin
        byte_position <= '0;
        overlong_flag <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        overlong_flag <= overlong_flag_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srtp_hp_queue.sv
// ----------------------------------------------------------------------------
// srtp_hp_queue
// Two-entry queue of packet records between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_hp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire srtp_hp_pkg::rec_t  push_data,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output srtp_hp_pkg::rec_t       head_data
);
  import srtp_hp_pkg::*;

  rec_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srtp_hp_back.sv
// ----------------------------------------------------------------------------
// srtp_hp_back
// Length back end: two stages turning a packet record into status, lengths,
// offsets and the srtp index, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_hp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srtp_hp_pkg::cfg_t  cfg,
  input  wire logic               rec_valid,
  input  wire srtp_hp_pkg::rec_t  rec_data,
  output logic                    rec_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srtp_hp_pkg::out_t       out_data
);
  import srtp_hp_pkg::*;

  // stage one
  logic              s1_valid;
  status_e           s1_pre;
  logic [HLEN_W-1:0] s1_hlen;
  logic [TRAIL_W-1:0] s1_trail;
  logic [POS_W-1:0]  s1_count;
  logic [15:0]       s1_seq;
  logic [31:0]       s1_ssrc;
  logic [31:0]       s1_roll;

  logic              adv1;
  logic              adv2;
  logic [BASE_W-1:0] base_len;
  logic [HLEN_W-1:0] ext_len;
  logic [HLEN_W-1:0] hlen_c;
  logic [TRAIL_W-1:0] trail_c;
  status_e           pre_c;

  assign adv2    = !out_valid || out_ready;
  assign adv1    = !s1_valid || adv2;
  assign rec_pop = rec_valid && adv1;

  assign base_len = BASE_W'(BASE_HDR_BYTES) + {1'b0, rec_data.csrc_count, 2'b00};
  assign ext_len  = HLEN_W'({rec_data.ext_words, 2'b00}) + HLEN_W'(EXT_HDR_BYTES);
  assign hlen_c   = HLEN_W'(base_len) + (rec_data.ext_flag ? ext_len : '0);
  assign trail_c  = cfg.secure_mode ?
                    (TRAIL_W'(cfg.auth_tag_bytes) + TRAIL_W'(cfg.mki_bytes)) : '0;

  always_comb begin
    priority if (rec_data.overlong) begin
      pre_c = ST_TOO_LONG;
    end else if (CMP_W'(rec_data.count) < CMP_W'(BASE_HDR_BYTES)) begin
      pre_c = ST_SHORT_BASE;
    end else if (rec_data.version != RTP_VERSION) begin
      pre_c = ST_BAD_VERSION;
    end else if (rec_data.ext_flag &&
                 CMP_W'(rec_data.count) < CMP_W'(base_len) + CMP_W'(EXT_HDR_BYTES)) begin
      pre_c = ST_SHORT_EXT;
    end else begin
      pre_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && rec_valid) begin
      s1_pre   <= pre_c;
      s1_hlen  <= hlen_c;
      s1_trail <= trail_c;
      s1_count <= rec_data.count;
      s1_seq   <= rec_data.seq;
      s1_ssrc  <= rec_data.ssrc;
      s1_roll  <= rec_data.rollover;
    end
  end

  // stage two
  logic [HLEN_W-1:0] count_h;
  logic [HLEN_W-1:0] diff;
  logic [HLEN_W-1:0] trail_h;
  logic [LEN_W-1:0]  mki_off;
  status_e           status_c;
  out_t              result;

  assign count_h = HLEN_W'(s1_count);
  assign trail_h = HLEN_W'(s1_trail);
  assign diff    = count_h - s1_hlen;
  assign mki_off = LEN_W'(count_h - trail_h);

  always_comb begin
    priority if (s1_pre != ST_OK) begin
      status_c = s1_pre;
    end else if (count_h < s1_hlen) begin
      status_c = ST_SHORT_HEADER;
    end else if (diff < trail_h) begin
      status_c = ST_SHORT_TRAILER;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    result.status          = status_c;
    result.byte_count      = LEN_W'(s1_count);
    result.sequence_number = s1_seq;
    result.source_id       = s1_ssrc;
    result.packet_index    = {s1_roll, s1_seq};
    if (status_c == ST_OK) begin
      result.hdr_bytes  = LEN_W'(s1_hlen);
      result.body_bytes = LEN_W'(diff - trail_h);
      result.mki_offset = mki_off;
      result.tag_offset = mki_off +
                          (cfg.secure_mode ? LEN_W'(cfg.mki_bytes) : '0);
    end else begin
      result.hdr_bytes  = '0;
      result.body_bytes = '0;
      result.mki_offset = '0;
      result.tag_offset = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srtp_packet_header_parser_unit.sv
// ----------------------------------------------------------------------------
// srtp_packet_header_parser_unit
// RTP/SRTP header parser taking one packet byte per beat.
//
// in channel: one byte per beat with a last-byte mark; the rollover counter is
// sampled with the first byte of each packet. Bytes are taken one per cycle
// for as long as the record queue has room.
// out channel: one result beat per packet, carrying status, lengths, offsets,
// sequence number, ssrc and the 48-bit srtp index, registered through the
// queue, stage one and the output register; back-to-back one-byte packets
// give one result per cycle while out_ready stays high.
// cfg channel: register index and data, always ready; write only while idle.
// A stalled receiver holds the output register; the back end and a two-entry
// record queue keep absorbing packets, and only when the queue is full is
// in_ready dropped. Reset empties the pipeline, restarts at the first byte
// of a packet and loads the register defaults (tag 10 bytes, no mki, clear).
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_packet_header_parser_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire srtp_hp_pkg::in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output srtp_hp_pkg::out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import srtp_hp_pkg::*;

  cfg_t cfg;
  logic rec_push;
  rec_t rec_in;
  logic rec_full;
  logic rec_pop;
  logic rec_valid;
  rec_t rec_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secure_mode    <= 1'b0;
      cfg.auth_tag_bytes <= AUTH_TAG_RESET;
      cfg.mki_bytes      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SECURE_MODE:    cfg.secure_mode    <= cfg_data[0];
        CFG_AUTH_TAG_BYTES: cfg.auth_tag_bytes <= cfg_data[5:0];
        CFG_MKI_BYTES:      cfg.mki_bytes      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  srtp_hp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .rec_push (rec_push),
    .rec_data (rec_in),
    .rec_full (rec_full)
  );

  srtp_hp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rec_push),
    .push_data  (rec_in),
    .full       (rec_full),
    .pop        (rec_pop),
    .head_valid (rec_valid),
    .head_data  (rec_head)
  );

  srtp_hp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (rec_valid),
    .rec_data  (rec_head),
    .rec_pop   (rec_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sim/srtp_packet_header_parser_unit_test.sv
// ----------------------------------------------------------------------------
// srtp_packet_header_parser_unit_test
// Self-checking bench for the RTP/SRTP header parser. Packets are streamed in
// one byte per beat: a short directed set covers the minimum lengths, each
// error status other than too-long and the trailer registers, then random
// traffic runs under several register settings. Results are predicted per
// packet and checked field by field against what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module srtp_packet_header_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srtp_hp_pkg::*;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int EXT_BODY_CAP  = 90;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  class header_scoreboard;
    logic        secure;
    logic [5:0]  tag_len;
    logic [4:0]  mki_len;
    int          pos;
    logic [1:0]  version;
    logic        ext;
    logic [3:0]  csrc_count;
    logic [15:0] seq;
    logic [31:0] ssrc;
    logic [15:0] ext_words;
    logic [31:0] roc;
    logic        overlong;
    out_t        pending_headers[$];
    int          mismatches;

    function new();
      secure     = 1'b0;
      tag_len    = AUTH_TAG_RESET;
      mki_len    = '0;
      pos        = 0;
      version    = '0;
      ext        = 1'b0;
      csrc_count = '0;
      seq        = '0;
      ssrc       = '0;
      ext_words  = '0;
      roc        = '0;
      overlong   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SECURE_MODE:    secure  = val[0];
        CFG_AUTH_TAG_BYTES: tag_len = val[5:0];
        CFG_MKI_BYTES:      mki_len = val[4:0];
        default: ;
      endcase
    endfunction

    function int waiting();
      return pending_headers.size();
    endfunction

    function void note_byte(in_t beat);
      int      base;
      int      hlen;
      int      trail;
      int      count;
      int      plen;
      status_e st;
      out_t    r;
      if (pos == 0) begin
        roc        = beat.rollover_count;
        version    = '0;
        ext        = 1'b0;
        csrc_count = '0;
        seq        = '0;
        ssrc       = '0;
        ext_words  = '0;
        overlong   = 1'b0;
      end
      if (pos >= MAX_PACKET_BYTES) begin
        overlong = 1'b1;
        pos      = MAX_PACKET_BYTES;
      end else begin
        base = BASE_HDR_BYTES + 4 * int'(csrc_count);
        if (pos == 0) begin
          version    = beat.packet_byte[7:6];
          ext        = beat.packet_byte[4];
          csrc_count = beat.packet_byte[3:0];
        end else if (pos == 2) seq[15:8] = beat.packet_byte;
        else if (pos == 3) seq[7:0] = beat.packet_byte;
        else if (pos >= 8 && pos <= 11) ssrc = {ssrc[23:0], beat.packet_byte};
        else if (pos == base + 2) ext_words[15:8] = beat.packet_byte;
        else if (pos == base + 3) ext_words[7:0] = beat.packet_byte;
        pos++;
      end
      if (!beat.last_byte) return;

      count = pos;
      base  = BASE_HDR_BYTES + 4 * int'(csrc_count);
      hlen  = base + (ext ? EXT_HDR_BYTES + 4 * int'(ext_words) : 0);
      trail = secure ? int'(tag_len) + int'(mki_len) : 0;
      if (overlong) st = ST_TOO_LONG;
      else if (count < BASE_HDR_BYTES) st = ST_SHORT_BASE;
      else if (version != RTP_VERSION) st = ST_BAD_VERSION;
      else if (ext && count < base + EXT_HDR_BYTES) st = ST_SHORT_EXT;
      else if (count < hlen) st = ST_SHORT_HEADER;
      else if (count - hlen < trail) st = ST_SHORT_TRAILER;
      else st = ST_OK;

      r = '0;
      r.status          = st;
      r.byte_count      = 12'(count);
      r.sequence_number = seq;
      r.source_id       = ssrc;
      r.packet_index    = {roc, seq};
      if (st == ST_OK) begin
        plen = count - hlen - trail;
        r.hdr_bytes  = 12'(hlen);
        r.body_bytes = 12'(plen);
        if (secure) begin
          r.mki_offset = 12'(hlen + plen);
          r.tag_offset = 12'(hlen + plen + int'(mki_len));
        end else begin
          r.mki_offset = 12'(count);
          r.tag_offset = 12'(count);
        end
      end
      pending_headers.push_back(r);
      pos      = 0;
      overlong = 1'b0;
    endfunction

    function void compare_field(string field, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_headers.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_headers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("hdr_bytes", want.hdr_bytes, got.hdr_bytes);
      compare_field("body_bytes", want.body_bytes, got.body_bytes);
      compare_field("mki_offset", want.mki_offset, got.mki_offset);
      compare_field("tag_offset", want.tag_offset, got.tag_offset);
      compare_field("sequence_number", want.sequence_number, got.sequence_number);
      compare_field("source_id", want.source_id, got.source_id);
      compare_field("packet_index", want.packet_index, got.packet_index);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  header_scoreboard sb = new();

  in_t         beat_q[$];
  logic [7:0]  pkt[$];
  int          bytes_queued = 0;
  int          bytes_accepted = 0;
  int          trailer_now = 0;
  int          cycle_count = 0;
  bit          tx_gappy = 1'b1;
  bit          rx_stally = 1'b1;
  int          tx_burst = 0;
  int          tx_gap = 0;
  int          rx_tick = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  srtp_packet_header_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** srtp_packet_header_parser_unit: FAILED **");
      $finish;
    end
  end

  // byte sender: bursts, with gaps while tx_gappy is set
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sb.note_byte(in_data);
        bytes_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          in_data  <= beat_q.pop_front();
          in_valid <= 1'b1;
          if (tx_burst > 0) begin
            tx_burst--;
          end else begin
            tx_burst = $urandom_range(0, 40);
            tx_gap   = tx_gappy ? $urandom_range(0, 6) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: rotating stall pattern while rx_stally is set, long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    rx_tick++;
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!rx_stally) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_tick % 64 == 0)
        rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      out_ready <= rx_pattern[rx_tick % 16];
    end
  end

  task automatic build_rtp(input logic [7:0] b0, input int ext_len, input int payload,
                           input int trailer);
    pkt.delete();
    pkt.push_back(b0);
    repeat (11) pkt.push_back(8'($urandom));
    repeat (4 * int'(b0[3:0])) pkt.push_back(8'($urandom));
    if (b0[4]) begin
      repeat (2) pkt.push_back(8'($urandom));
      pkt.push_back(ext_len[15:8]);
      pkt.push_back(ext_len[7:0]);
      repeat (4 * ext_len) if (pkt.size() < EXT_BODY_CAP) pkt.push_back(8'($urandom));
    end
    repeat (payload + trailer) pkt.push_back(8'($urandom));
  endtask

  task automatic queue_packet(input int len, input logic [31:0] roc);
    in_t beat;
    for (int i = 0; i < len; i++) begin
      beat.packet_byte    = (i < pkt.size()) ? pkt[i] : 8'($urandom);
      beat.last_byte      = (i == len - 1);
      beat.rollover_count = (i == 0) ? roc : $urandom;
      beat_q.push_back(beat);
    end
    bytes_queued += len;
  endtask

  task automatic random_packet(output int len);
    int         kind;
    int         full;
    int         ext_len;
    logic [7:0] b0;
    kind    = $urandom_range(0, 99);
    b0      = {2'b10, 1'($urandom), ($urandom_range(0, 2) == 0),
               ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2))};
    ext_len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535))
                                           : int'($urandom_range(0, 3));
    if (kind >= 85) b0 = 8'($urandom);
    build_rtp(b0, ext_len, $urandom_range(0, 24), trailer_now);
    full = pkt.size();
    if (kind < 70) begin
      len = full;
      if ($urandom_range(0, 7) == 0) len = full + $urandom_range(0, 4) - 2;
    end else if (kind < 85) begin
      len = $urandom_range(1, full);
    end else begin
      len = $urandom_range(1, 30);
    end
    if (len < 1) len = 1;
    queue_packet(len, $urandom);
  endtask

  task automatic random_traffic(input int byte_budget, input int min_packets);
    int queued;
    int packets;
    int len;
    queued  = 0;
    packets = 0;
    while (queued < byte_budget || packets < min_packets) begin
      random_packet(len);
      queued += len;
      packets++;
    end
  endtask

  task automatic drain();
    while (bytes_accepted != bytes_queued || sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  task automatic configure(input logic [7:0] secure, input logic [7:0] tag,
                           input logic [7:0] mki);
    write_reg(CFG_SECURE_MODE, secure);
    write_reg(CFG_AUTH_TAG_BYTES, tag);
    write_reg(CFG_MKI_BYTES, mki);
    write_reg(CFG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
    trailer_now = secure[0] ? int'(tag[5:0]) + int'(mki[4:0]) : 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // all-ones and all-zero minimal headers
    build_rtp(8'h80, 0, 0, 0);
    for (int i = 1; i < 12; i++) pkt[i] = 8'hFF;
    queue_packet(12, 32'hFFFF_FFFF);
    for (int i = 1; i < 12; i++) pkt[i] = 8'h00;
    queue_packet(12, 32'h0000_0000);
    // too short for the fixed header
    build_rtp(8'hBF, 0, 0, 0);
    queue_packet(1, $urandom);
    queue_packet(11, $urandom);
    // wrong version numbers
    build_rtp(8'h00, 0, 4, 0);
    queue_packet(16, $urandom);
    build_rtp(8'h40, 0, 4, 0);
    queue_packet(16, $urandom);
    build_rtp(8'hC0, 0, 4, 0);
    queue_packet(16, $urandom);
    // extension header cut short, csrc list cut short
    build_rtp(8'h90, 1, 0, 0);
    queue_packet(15, $urandom);
    build_rtp(8'h8F, 0, 0, 0);
    queue_packet(40, $urandom);
    // extension exactly complete, padding bit set, huge extension length
    build_rtp(8'h90, 1, 0, 0);
    queue_packet(pkt.size(), $urandom);
    build_rtp(8'hA0, 0, 3, 0);
    queue_packet(pkt.size(), $urandom);
    build_rtp(8'h9F, 16'hFFFF, 0, 0);
    queue_packet(pkt.size(), $urandom);
    build_rtp(8'h9F, 2, 5, 0);
    queue_packet(pkt.size(), $urandom);
    build_rtp(8'h80, 0, 0, 0);
    queue_packet(5, $urandom);
    drain();

    // trailer handling: exact fit, short by one, with payload
    configure(8'h01, 8'd10, 8'd4);
    build_rtp(8'h80, 0, 0, 14);
    queue_packet(26, $urandom);
    queue_packet(25, $urandom);
    build_rtp(8'h81, 0, 5, 14);
    queue_packet(pkt.size(), $urandom);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(8'h00, 8'd32, 8'd16);
        1: configure(8'h01, 8'd32, 8'd16);
        2: configure(8'h01, 8'd0, 8'd0);
        3: configure(8'hFF, 8'hFF, 8'hFF);
        4: configure(8'h01, 8'($urandom_range(0, 32)), 8'($urandom_range(0, 16)));
        default: configure(8'hFE, 8'd10, 8'd4);
      endcase
      tx_gappy  = (phase != 1 && phase != 4);
      rx_stally = (phase % 3 != 2);
      if (phase == 1 || phase == 4) begin
        hold_requests++;
        // short packets so the queue fills while the receiver holds off
        repeat (8) begin
          build_rtp(8'h80, 0, 0, 0);
          queue_packet($urandom_range(1, 8), $urandom);
        end
      end
      random_traffic(20, 2);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("** srtp_packet_header_parser_unit: PASSED **");
    end else begin
      $display("** srtp_packet_header_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: srtp_packet_header_parser_unit.f
hw/rtl/srtp_hp_pkg.sv
hw/rtl/srtp_hp_front.sv
hw/rtl/srtp_hp_queue.sv
hw/rtl/srtp_hp_back.sv
hw/rtl/srtp_packet_header_parser_unit.sv
sim/srtp_packet_header_parser_unit_test.sv
